// File: src/tlca_pkg.sv
package tlca_pkg;

    localparam int NODE_W   = 12;
    localparam int DEPTH_W  = 12;
    localparam int DIST_W   = 48;
    localparam int WEIGHT_W = 32;
    localparam int LVL_W    = 4;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [LVL_W-1:0]   lvl_t;

    localparam depth_t DEPTH_MAX = '1;
    localparam dist_t  DIST_MAX  = '1;

    typedef struct packed {
        logic                req_type;
        node_t               node_a;
        node_t               node_b;
        logic [WEIGHT_W-1:0] weight;
    } req_word_t;

    typedef struct packed {
        node_t ancestor;
        dist_t distance;
    } rsp_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_ADD_LIFT,
        ST_Q_RD,
        ST_Q_SWAP,
        ST_Q_FIRST,
        ST_Q_LIFT,
        ST_Q_DOWN,
        ST_Q_PAR,
        ST_Q_DIST,
        ST_Q_NULL
    } state_t;

    // requests to the node store: one write and two reads per memory
    typedef struct packed {
        logic   jt_we;
        node_t  jt_wnode;
        lvl_t   jt_wlvl;
        node_t  jt_wdata;
        node_t  jt_rnode0;
        lvl_t   jt_rlvl0;
        node_t  jt_rnode1;
        lvl_t   jt_rlvl1;
        logic   nd_we;
        node_t  nd_wnode;
        depth_t nd_wdepth;
        dist_t  nd_wdist;
        node_t  nd_rnode0;
        node_t  nd_rnode1;
    } mem_req_t;

    typedef struct packed {
        node_t  jt_q0;
        node_t  jt_q1;
        depth_t dep_q0;
        depth_t dep_q1;
        dist_t  dist_q0;
        dist_t  dist_q1;
    } mem_rsp_t;

endpackage

// File: src/tlca_store.sv
module tlca_store #(
    parameter int NODES  = 4096,
    parameter int LEVELS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tlca_pkg::mem_req_t req,
    output tlca_pkg::mem_rsp_t rsp
);

    localparam int JDEPTH = NODES * LEVELS;
    localparam int JAW    = $clog2(JDEPTH);
    localparam int NAW    = $clog2(NODES);
    localparam int NDW    = tlca_pkg::DEPTH_W + tlca_pkg::DIST_W;

    // jump table row per node, LEVELS entries, ancestor at 2^k steps
    logic [tlca_pkg::NODE_W-1:0] jump_mem [JDEPTH];
    // depth and root distance share one word per node, depth on top
    logic [NDW-1:0]              node_mem [NODES];

    logic [JAW-1:0] jt_wa;
    logic [JAW-1:0] jt_ra0;
    logic [JAW-1:0] jt_ra1;
    logic [NAW-1:0] nd_wa;
    logic [NAW-1:0] nd_ra0;
    logic [NAW-1:0] nd_ra1;

    tlca_pkg::node_t  jt_q0_reg;
    tlca_pkg::node_t  jt_q1_reg;
    logic [NDW-1:0]   nd_q0_reg;
    logic [NDW-1:0]   nd_q1_reg;
    logic             fwd_hit_reg;
    tlca_pkg::node_t  fwd_data_reg;

    function automatic logic [JAW-1:0] jt_addr(input tlca_pkg::node_t node,
                                               input tlca_pkg::lvl_t  lvl);
        jt_addr = JAW'(JAW'(node) * JAW'(LEVELS) + JAW'(lvl));
    endfunction

    assign jt_wa  = jt_addr(req.jt_wnode, req.jt_wlvl);
    assign jt_ra0 = jt_addr(req.jt_rnode0, req.jt_rlvl0);
    assign jt_ra1 = jt_addr(req.jt_rnode1, req.jt_rlvl1);
    assign nd_wa  = NAW'(req.nd_wnode);
    assign nd_ra0 = NAW'(req.nd_rnode0);
    assign nd_ra1 = NAW'(req.nd_rnode1);

    always_ff @(posedge clk)
    begin
        if (req.jt_we)
        begin
            jump_mem[jt_wa] <= req.jt_wdata;
        end
        jt_q0_reg <= jump_mem[jt_ra0];
        jt_q1_reg <= jump_mem[jt_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (req.nd_we)
        begin
            node_mem[nd_wa] <= {req.nd_wdepth, req.nd_wdist};
        end
        nd_q0_reg <= node_mem[nd_ra0];
        nd_q1_reg <= node_mem[nd_ra1];
    end

    // row fill can read the entry it writes in the same cycle (node is its
    // own ancestor); port 0 returns the new value then
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= req.jt_we && (jt_wa == jt_ra0);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= req.jt_wdata;
    end

    assign rsp.jt_q0   = fwd_hit_reg ? fwd_data_reg : jt_q0_reg;
    assign rsp.jt_q1   = jt_q1_reg;
    assign rsp.dep_q0  = nd_q0_reg[NDW-1 -: tlca_pkg::DEPTH_W];
    assign rsp.dep_q1  = nd_q1_reg[NDW-1 -: tlca_pkg::DEPTH_W];
    assign rsp.dist_q0 = nd_q0_reg[tlca_pkg::DIST_W-1:0];
    assign rsp.dist_q1 = nd_q1_reg[tlca_pkg::DIST_W-1:0];

endmodule

// File: src/tree_lca_distance_engine.sv
// Weighted rooted tree engine: lowest common ancestor by binary lifting.
// An add word (req_type 0) stores node_a under parent node_b with edge weight
// `weight`; the root is added as its own parent. Nodes must be added parent
// first. Each add records the node's depth (saturating at 4095), its weighted
// distance to the root (saturating at 2^48-1) and its row of ancestors at
// 1, 2, 4 .. 2^(LEVELS-1) steps. A query word (req_type 1) returns the lowest
// common ancestor of node_a and node_b and the weighted path length between
// them; adds return nothing. Words naming a node >= NODES are dropped (add)
// or answered with zeros (query). Node data is held in two synchronous
// memories (jump table; depth with root distance) with registered reads and no
// clearing after reset: querying a node never added gives undefined fields.
// One word is worked on at a time; the request side is ready whenever the
// sequencer is idle, and a finished result waits in an output register so the
// next word can be taken meanwhile. An add fills the node's row with one
// jump-table read per level; a query makes one lifting pass and one descent
// pass, each one jump-table read per level, and skips the descent when one
// node is an ancestor of the other.
module tree_lca_distance_engine #(
    parameter int NODES  = 4096,
    parameter int LEVELS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  tlca_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output tlca_pkg::rsp_word_t rsp_word
);

    localparam tlca_pkg::lvl_t LVL_TOP = tlca_pkg::lvl_t'(LEVELS - 1);

    // sequencer state
    tlca_pkg::state_t    state_reg, state_next;
    tlca_pkg::lvl_t      lvl_reg, lvl_next;

    // working registers; x and y hold node_a/node_b, later the two climbers
    tlca_pkg::node_t     x_reg, x_next;
    tlca_pkg::node_t     y_reg, y_next;
    tlca_pkg::node_t     t_reg, t_next;      // candidate ancestor of y
    tlca_pkg::node_t     lca_reg, lca_next;
    tlca_pkg::depth_t    dx_reg, dx_next;    // depth of the shallower node
    logic [tlca_pkg::WEIGHT_W-1:0] w_reg, w_next;
    logic [tlca_pkg::DIST_W:0]     sum_reg, sum_next;

    // output register
    logic                rsp_valid_reg, rsp_valid_next;
    tlca_pkg::rsp_word_t rsp_word_reg, rsp_word_next;

    tlca_pkg::mem_req_t  mem_req;
    tlca_pkg::mem_rsp_t  mem_rsp;

    logic                accept;
    logic                in_range;
    logic                rsp_free;
    tlca_pkg::lvl_t      lvl_dn;
    tlca_pkg::lvl_t      lvl_dn2;
    logic                swap;
    logic                take;
    tlca_pkg::node_t     lift_y;
    tlca_pkg::node_t     lift_t;
    logic                down_diff;
    tlca_pkg::node_t     down_x;
    tlca_pkg::node_t     down_y;
    tlca_pkg::depth_t    add_depth;
    logic [tlca_pkg::DIST_W:0] add_sum;
    tlca_pkg::dist_t     add_dist;
    logic [tlca_pkg::DIST_W:0] twice;
    logic [tlca_pkg::DIST_W:0] diff;
    tlca_pkg::dist_t     path_dist;

    tlca_store #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rsp   (mem_rsp)
    );

    assign req_ready = (state_reg == tlca_pkg::ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign in_range  = (32'(req_word.node_a) < NODES) && (32'(req_word.node_b) < NODES);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    assign lvl_dn  = (lvl_reg != '0) ? lvl_reg - 1'b1 : '0;
    assign lvl_dn2 = (lvl_dn != '0) ? lvl_dn - 1'b1 : '0;

    // deeper node becomes y, the one that climbs first
    assign swap = mem_rsp.dep_q0 > mem_rsp.dep_q1;

    // lifting pass: depth of candidate t arrives together with both
    // possible next candidates (one level down from y and from t)
    assign take   = mem_rsp.dep_q0 >= dx_reg;
    assign lift_y = take ? t_reg : y_reg;
    assign lift_t = take ? mem_rsp.jt_q1 : mem_rsp.jt_q0;

    // descent pass: move both while their ancestors differ
    assign down_diff = mem_rsp.jt_q0 != mem_rsp.jt_q1;
    assign down_x    = down_diff ? mem_rsp.jt_q0 : x_reg;
    assign down_y    = down_diff ? mem_rsp.jt_q1 : y_reg;

    // new node under its parent, both saturating
    assign add_depth = (mem_rsp.dep_q0 == tlca_pkg::DEPTH_MAX) ?
                       tlca_pkg::DEPTH_MAX : mem_rsp.dep_q0 + 1'b1;
    assign add_sum   = {1'b0, mem_rsp.dist_q0} + (tlca_pkg::DIST_W + 1)'(w_reg);
    assign add_dist  = add_sum[tlca_pkg::DIST_W] ? tlca_pkg::DIST_MAX :
                       add_sum[tlca_pkg::DIST_W-1:0];

    // d(a) + d(b) - 2 d(lca), clamped to the output range
    assign twice     = {mem_rsp.dist_q0, 1'b0};
    assign diff      = sum_reg - twice;
    assign path_dist = (sum_reg <= twice) ? '0 :
                       diff[tlca_pkg::DIST_W] ? tlca_pkg::DIST_MAX :
                       diff[tlca_pkg::DIST_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlca_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_word.req_type)
                        tlca_pkg::REQ_ADD:
                            state_next = in_range ? tlca_pkg::ST_ADD_RD : tlca_pkg::ST_IDLE;
                        tlca_pkg::REQ_QUERY:
                            state_next = in_range ? tlca_pkg::ST_Q_RD : tlca_pkg::ST_Q_NULL;
                        default:
                            state_next = tlca_pkg::ST_IDLE;
                    endcase
                end
            end
            tlca_pkg::ST_ADD_RD:
                state_next = tlca_pkg::ST_ADD_WR;
            tlca_pkg::ST_ADD_WR:
                state_next = (LEVELS == 1) ? tlca_pkg::ST_IDLE : tlca_pkg::ST_ADD_LIFT;
            tlca_pkg::ST_ADD_LIFT:
                state_next = (lvl_reg == LVL_TOP) ? tlca_pkg::ST_IDLE : tlca_pkg::ST_ADD_LIFT;
            tlca_pkg::ST_Q_RD:
                state_next = tlca_pkg::ST_Q_SWAP;
            tlca_pkg::ST_Q_SWAP:
                state_next = tlca_pkg::ST_Q_FIRST;
            tlca_pkg::ST_Q_FIRST:
                state_next = tlca_pkg::ST_Q_LIFT;
            tlca_pkg::ST_Q_LIFT:
            begin
                if (lvl_reg == '0)
                begin
                    state_next = (x_reg == lift_y) ? tlca_pkg::ST_Q_DIST : tlca_pkg::ST_Q_DOWN;
                end
            end
            tlca_pkg::ST_Q_DOWN:
            begin
                if (lvl_reg == '0)
                begin
                    state_next = tlca_pkg::ST_Q_PAR;
                end
            end
            tlca_pkg::ST_Q_PAR:
                state_next = tlca_pkg::ST_Q_DIST;
            tlca_pkg::ST_Q_DIST,
            tlca_pkg::ST_Q_NULL:
            begin
                if (rsp_free)
                begin
                    state_next = tlca_pkg::ST_IDLE;
                end
            end
            default:
                state_next = tlca_pkg::ST_IDLE;
        endcase
    end

    // memory requests and register updates
    always_comb
    begin
        mem_req        = '0;
        lvl_next       = lvl_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        t_next         = t_reg;
        lca_next       = lca_reg;
        dx_next        = dx_reg;
        w_next         = w_reg;
        sum_next       = sum_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_word_next  = rsp_word_reg;

        unique case (state_reg)
            tlca_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    x_next = req_word.node_a;
                    y_next = req_word.node_b;
                    w_next = req_word.weight;
                end
            end
            tlca_pkg::ST_ADD_RD:
            begin
                // first ancestor is the parent itself
                mem_req.jt_we     = 1'b1;
                mem_req.jt_wnode  = x_reg;
                mem_req.jt_wlvl   = '0;
                mem_req.jt_wdata  = y_reg;
                mem_req.nd_rnode0 = y_reg;
            end
            tlca_pkg::ST_ADD_WR:
            begin
                mem_req.nd_we    = 1'b1;
                mem_req.nd_wnode = x_reg;
                if (x_reg == y_reg)
                begin
                    mem_req.nd_wdepth = '0;
                    mem_req.nd_wdist  = '0;
                end
                else
                begin
                    mem_req.nd_wdepth = add_depth;
                    mem_req.nd_wdist  = add_dist;
                end
                mem_req.jt_rnode0 = y_reg;
                mem_req.jt_rlvl0  = '0;
                lvl_next          = tlca_pkg::lvl_t'(1);
            end
            tlca_pkg::ST_ADD_LIFT:
            begin
                // entry k is the 2^(k-1) ancestor of the 2^(k-1) ancestor
                mem_req.jt_we     = 1'b1;
                mem_req.jt_wnode  = x_reg;
                mem_req.jt_wlvl   = lvl_reg;
                mem_req.jt_wdata  = mem_rsp.jt_q0;
                mem_req.jt_rnode0 = mem_rsp.jt_q0;
                mem_req.jt_rlvl0  = lvl_reg;
                lvl_next          = lvl_reg + 1'b1;
            end
            tlca_pkg::ST_Q_RD:
            begin
                mem_req.nd_rnode0 = x_reg;
                mem_req.nd_rnode1 = y_reg;
            end
            tlca_pkg::ST_Q_SWAP:
            begin
                sum_next = {1'b0, mem_rsp.dist_q0} + {1'b0, mem_rsp.dist_q1};
                x_next   = swap ? y_reg : x_reg;
                y_next   = swap ? x_reg : y_reg;
                dx_next  = swap ? mem_rsp.dep_q1 : mem_rsp.dep_q0;
                mem_req.jt_rnode0 = swap ? x_reg : y_reg;
                mem_req.jt_rlvl0  = LVL_TOP;
                lvl_next          = LVL_TOP;
            end
            tlca_pkg::ST_Q_FIRST:
            begin
                t_next            = mem_rsp.jt_q0;
                mem_req.nd_rnode0 = mem_rsp.jt_q0;
                mem_req.jt_rnode0 = y_reg;
                mem_req.jt_rlvl0  = lvl_dn;
                mem_req.jt_rnode1 = mem_rsp.jt_q0;
                mem_req.jt_rlvl1  = lvl_dn;
            end
            tlca_pkg::ST_Q_LIFT:
            begin
                y_next = lift_y;
                if (lvl_reg == '0)
                begin
                    if (x_reg == lift_y)
                    begin
                        lca_next          = x_reg;
                        mem_req.nd_rnode0 = x_reg;
                    end
                    else
                    begin
                        mem_req.jt_rnode0 = x_reg;
                        mem_req.jt_rlvl0  = LVL_TOP;
                        mem_req.jt_rnode1 = lift_y;
                        mem_req.jt_rlvl1  = LVL_TOP;
                        lvl_next          = LVL_TOP;
                    end
                end
                else
                begin
                    t_next            = lift_t;
                    mem_req.nd_rnode0 = lift_t;
                    mem_req.jt_rnode0 = lift_y;
                    mem_req.jt_rlvl0  = lvl_dn2;
                    mem_req.jt_rnode1 = lift_t;
                    mem_req.jt_rlvl1  = lvl_dn2;
                    lvl_next          = lvl_dn;
                end
            end
            tlca_pkg::ST_Q_DOWN:
            begin
                x_next            = down_x;
                y_next            = down_y;
                mem_req.jt_rnode0 = down_x;
                mem_req.jt_rlvl0  = lvl_dn;
                mem_req.jt_rnode1 = down_y;
                mem_req.jt_rlvl1  = lvl_dn;
                lvl_next          = lvl_dn;
            end
            tlca_pkg::ST_Q_PAR:
            begin
                lca_next          = mem_rsp.jt_q0;
                mem_req.nd_rnode0 = mem_rsp.jt_q0;
            end
            tlca_pkg::ST_Q_DIST:
            begin
                // keep reading the ancestor's distance while the output waits
                mem_req.nd_rnode0 = lca_reg;
                if (rsp_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_word_next.ancestor = lca_reg;
                    rsp_word_next.distance = path_dist;
                end
            end
            tlca_pkg::ST_Q_NULL:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_word_next  = '0;
                end
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlca_pkg::ST_IDLE;
            lvl_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        t_reg        <= t_next;
        lca_reg      <= lca_next;
        dx_reg       <= dx_next;
        w_reg        <= w_next;
        sum_reg      <= sum_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // a result only ever comes out of the query tail states
    a_rsp_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |->
            ($past(state_reg) == tlca_pkg::ST_Q_DIST ||
             $past(state_reg) == tlca_pkg::ST_Q_NULL))
        else $error("result raised outside a query");

    // queries never touch the jump table write port
    a_jt_write_add_only: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.jt_we |->
            (state_reg == tlca_pkg::ST_ADD_RD || state_reg == tlca_pkg::ST_ADD_LIFT))
        else $error("jump table written outside an add");

    // an add word goes straight into the add sequence or is dropped
    a_add_path: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_word.req_type == tlca_pkg::REQ_ADD) |=>
            (state_reg == tlca_pkg::ST_ADD_RD || state_reg == tlca_pkg::ST_IDLE))
        else $error("add word took a wrong path");

endmodule
